/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands for the decoder checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* rtl/vlid_pkg.sv */
// ----------------------------------------------------------------------------
// vlid_pkg
// shared types and constants of the variable-length instruction decoder
// ----------------------------------------------------------------------------
`default_nettype none

package vlid_pkg;

	localparam int ADDR_WIDTH_DEF = 32;

	// instruction classes (bits 31..26)
	localparam logic [5:0] CLS_ALU     = 6'd0;
	localparam logic [5:0] CLS_MUL     = 6'd1;
	localparam logic [5:0] CLS_CONV    = 6'd2;
	localparam logic [5:0] CLS_CMP     = 6'd3;
	localparam logic [5:0] CLS_SPECIAL = 6'd4;
	localparam logic [5:0] CLS_CTRL    = 6'd5;
	localparam logic [5:0] CLS_MOVE    = 6'd6;
	localparam logic [5:0] CLS_BRANCH  = 6'd7;
	localparam logic [5:0] CLS_REGMEM  = 6'd8;
	localparam logic [5:0] CLS_SHIFT   = 6'd9;
	localparam logic [5:0] CLS_LOADIMM = 6'd10;
	localparam logic [5:0] CLS_CREG    = 6'd11;
	localparam logic [5:0] CLS_TRAP    = 6'd12;
	localparam logic [5:0] CLS_FLOAT   = 6'd13;
	localparam logic [3:0] CLS_INVALID = 4'd14;

	// trap subclasses that the decoder supports
	localparam logic [7:0] TRAP_RANGE     = 8'd12;
	localparam logic [7:0] TRAP_ARRAY     = 8'd13;
	localparam logic [7:0] TRAP_NIL_GUARD = 8'd19;
	localparam logic [7:0] TRAP_NIL_PTR   = 8'd20;

	// reg-mem opcode that takes a 64-bit immediate
	localparam logic [4:0] OP_RM_LDI = 5'd3;

	// bank flag patterns
	localparam logic [2:0] BANK_DEST  = 3'b100;
	localparam logic [2:0] BANK_DA    = 3'b110;
	localparam logic [2:0] BANK_SRC_A = 3'b010;

	// configuration register byte offsets
	localparam logic [2:0] REG_START_ADDRESS = 3'd0;

	typedef enum logic [1:0] {
		ST_VALID     = 2'd0,
		ST_BAD_ENC   = 2'd1,
		ST_BAD_CLASS = 2'd2,
		ST_BAD_TRAP  = 2'd3
	} status_t;

	// decoded fields of one instruction word
	typedef struct packed {
		logic [3:0]  inst_class;
		logic [7:0]  op_code;
		logic [4:0]  dest_reg;
		logic [4:0]  src_reg_a;
		logic [4:0]  src_reg_b;
		logic [15:0] small_imm;
		logic [2:0]  bank_bits;
		status_t     status;
		logic [1:0]  need;        // extension words owed
		logic        branch_ok;   // branch with a valid opcode
	} dec_t;

	// one result item
	typedef struct packed {
		logic [31:0] inst_address;
		logic [3:0]  inst_class;
		logic [7:0]  op_code;
		logic [4:0]  dest_reg;
		logic [4:0]  src_reg_a;
		logic [4:0]  src_reg_b;
		logic [15:0] small_imm;
		logic [2:0]  bank_bits;
		logic [31:0] ext_low;
		logic [31:0] ext_high;
		logic [31:0] branch_target;
		status_t     decode_status;
	} res_t;

endpackage

`default_nettype wire

/* rtl/vlid_decode.sv */
// ----------------------------------------------------------------------------
// vlid_decode
// field extraction and reserved-bit checks of one instruction word
// ----------------------------------------------------------------------------
`default_nettype none

module vlid_decode import vlid_pkg::*; (
	input  wire logic [31:0] word,
	output dec_t             dec
);

	logic [5:0] cls;
	logic [4:0] rd, ra, rb, op5;
	logic [5:0] op6;
	logic       bad;

	assign cls = word[31:26];
	assign rd  = word[25:21];
	assign ra  = word[20:16];
	assign rb  = word[15:11];
	assign op5 = word[4:0];
	assign op6 = word[5:0];

	always_comb begin
		dec = '0;
		bad = 1'b0;
		dec.inst_class = cls[3:0];
		case (cls)
			CLS_ALU: begin
				dec.op_code = {3'b0, op5};
				dec.dest_reg = rd; dec.src_reg_a = ra; dec.src_reg_b = rb;
				dec.bank_bits = word[10:8];
				// unary form needs src a zero and an integer src a bank
				bad = (word[7:5] != 3'd0) || (op5 > 5'd6) ||
				      ((op5 == 5'd6) && ((ra != 5'd0) || word[9]));
			end
			CLS_MUL: begin
				dec.op_code = {2'b0, op6};
				dec.dest_reg = rd; dec.src_reg_a = ra; dec.src_reg_b = rb;
				bad = (word[10:6] != 5'd0) || (op6 > 6'd8);
			end
			CLS_CONV: begin
				dec.op_code = {2'b0, op6};
				dec.dest_reg = rd; dec.src_reg_a = ra;
				bad = (word[15:6] != 10'd0) || (op6 > 6'd1);
			end
			CLS_CMP: begin
				dec.op_code = {3'b0, op5};
				dec.dest_reg = rd; dec.src_reg_a = ra;
				bad = (word[15:5] != 11'd0) || (op5 > 5'd1);
			end
			CLS_SPECIAL: begin
				dec.op_code = {3'b0, op5};
				dec.dest_reg = rd;
				bad = (word[20:5] != 16'd0) || (op5 > 5'd2);
			end
			CLS_CTRL: begin
				dec.op_code = {3'b0, op5};
				if (op5 == 5'd3) begin
					dec.src_reg_a = ra;
				end else begin
					bad = (op5 > 5'd3) || (word[25:5] != 21'd0);
				end
			end
			CLS_MOVE: begin
				dec.dest_reg = rd; dec.src_reg_a = ra;
				bad = (word[15:0] != 16'd0);
			end
			CLS_BRANCH: begin
				dec.op_code = {3'b0, op5};
				dec.need = 2'd1;
				if (op5 <= 5'd9) begin
					dec.src_reg_a = ra;
				end
				dec.branch_ok = (op5 <= 5'd11);
				bad = (op5 > 5'd11);
			end
			CLS_REGMEM: begin
				dec.op_code = {3'b0, op5};
				if (op5 > 5'd15) begin
					bad = 1'b1;
				end else begin
					dec.need = (op5 == OP_RM_LDI) ? 2'd2 : 2'd1;
					dec.dest_reg = rd;
					if (!(op5 inside {OP_RM_LDI, 5'd5, 5'd9})) begin
						dec.src_reg_a = ra; dec.src_reg_b = rb;
						dec.small_imm = {14'd0, word[7:6]};
					end
					if (op5 inside {5'd2, OP_RM_LDI, 5'd4, 5'd5, 5'd11, 5'd12}) begin
						dec.bank_bits = BANK_DEST;
					end
				end
			end
			CLS_SHIFT: begin
				dec.op_code = {3'b0, op5};
				dec.dest_reg = rd; dec.src_reg_a = ra; dec.src_reg_b = rb;
				bad = (word[10:5] != 6'd0) || (op5 > 5'd7);
			end
			CLS_LOADIMM: begin
				dec.op_code = {3'b0, op5};
				dec.dest_reg = rd;
				if (op5 <= 5'd1) begin
					dec.small_imm = word[20:5];
				end
				if (op5 inside {5'd3, 5'd4, 5'd6, 5'd7}) begin
					dec.bank_bits = BANK_DEST;
				end
				bad = (op5 > 5'd7);
			end
			CLS_CREG: begin
				dec.op_code = {3'b0, op5};
				dec.dest_reg = rd; dec.src_reg_a = ra;
				bad = (word[15:5] != 11'd0) || (op5 > 5'd9);
			end
			CLS_TRAP: begin
				dec.op_code = word[15:8];
				if (word[15:8] inside {TRAP_NIL_GUARD, TRAP_NIL_PTR}) begin
					dec.src_reg_a = ra;
				end else if (word[15:8] == TRAP_ARRAY) begin
					dec.src_reg_a = ra; dec.dest_reg = rd;
				end else if (word[15:8] == TRAP_RANGE) begin
					dec.src_reg_a = ra;
					dec.small_imm = {8'd0, word[7:0]};
				end else begin
					dec.status = ST_BAD_TRAP;
				end
			end
			CLS_FLOAT: begin
				dec.op_code = {2'b0, op6};
				dec.dest_reg = rd; dec.src_reg_a = ra;
				dec.bank_bits = BANK_DA;
				bad = (word[10:6] != 5'd0) || (rb != 5'd0) || (op6 > 6'd6);
			end
			default: begin
				// classes above the table carry nothing but the marker and the status
				dec.inst_class = CLS_INVALID;
				dec.status = ST_BAD_CLASS;
			end
		endcase
		if (bad) begin
			dec.status = ST_BAD_ENC;
		end
	end

endmodule

`default_nettype wire

/* rtl/vlid_out_buf.sv */
// ----------------------------------------------------------------------------
// vlid_out_buf
// result register with a skid entry behind it
// ----------------------------------------------------------------------------
`default_nettype none

module vlid_out_buf import vlid_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  res_t      push_data,
	output logic      can_push,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_data
);

	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic pop;

	assign pop       = out_valid_q && out_ready;
	assign can_push  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			if (!out_valid_q) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/variable_length_instruction_decoder_core.sv */
// results: the request carrying an instruction's last word pushes its result into
//   the result register, or into the skid entry while an earlier result waits
// throughput: one code word per cycle while the skid entry is free, set by the
//   single decode pass between the accepted word and the result register
// reset: arst_n clears the address counter, pending count, held words,
//   start_address and both result entries; no clearing pass is needed
// ----------------------------------------------------------------------------
// variable_length_instruction_decoder_core
// decodes a stream of 32-bit code words into one result per instruction
// ----------------------------------------------------------------------------
`default_nettype none

module variable_length_instruction_decoder_core import vlid_pkg::*; #(
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// word requests
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [31:0] code_word, [32] restart, [39:33] zero
	input  wire logic [39:0]  s_tdata,
	// result requests
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [31:0] inst_address, [35:32] inst_class, [43:36] op_code,
	// [48:44] dest_reg, [53:49] src_reg_a, [58:54] src_reg_b,
	// [74:59] small_imm, [77:75] bank_bits, [109:78] ext_low,
	// [141:110] ext_high, [173:142] branch_target, [175:174] decode_status
	output logic [175:0]      m_tdata,
	// configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic [ADDR_WIDTH-1:0] WORD_BYTES = ADDR_WIDTH'(4);
	localparam logic [ADDR_WIDTH-1:0] PAIR_BYTES = ADDR_WIDTH'(8);

	// ------------------------------------------------------------------
	// configuration register
	// ------------------------------------------------------------------
	logic [31:0] start_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	// only bit 2 selects a register, the low bits are byte lanes
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_START_ADDRESS[2]);
	assign prdata = (paddr[2] == REG_START_ADDRESS[2]) ? start_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 32'd0;
		end else if (cfg_wr) begin
			start_q <= pwdata;
		end
	end

	// ------------------------------------------------------------------
	// stream state
	// ------------------------------------------------------------------
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [1:0]            pend_q;
	logic [31:0]           held_inst_q;
	logic [31:0]           held_ext_q;

	logic [31:0]           word;
	logic                  restart;
	logic                  accept;
	logic                  can_push;

	logic [ADDR_WIDTH-1:0] cur_addr;
	logic [1:0]            cur_pend;
	logic [31:0]           dec_word;
	dec_t                  dec;

	assign word    = s_tdata[31:0];
	assign restart = s_tdata[32];
	assign accept  = s_tvalid && s_tready;
	// a word only waits when both result entries are full
	assign s_tready = can_push;

	// restart reloads the counter and drops any half-read instruction
	assign cur_addr = restart ? start_q[ADDR_WIDTH-1:0] : addr_q;
	assign cur_pend = restart ? 2'd0 : pend_q;

	// a fresh word is decoded directly, the final extension decodes the held word
	assign dec_word = (cur_pend == 2'd0) ? word : held_inst_q;

	vlid_decode u_decode (
		.word (dec_word),
		.dec  (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			pend_q      <= 2'd0;
			held_inst_q <= 32'd0;
			held_ext_q  <= 32'd0;
		end else if (accept) begin
			addr_q <= cur_addr + WORD_BYTES;
			case (cur_pend)
				2'd0: begin
					pend_q <= dec.need;
					if (dec.need != 2'd0) begin
						held_inst_q <= word;
					end
				end
				2'd2: begin
					// first half of the ldi immediate
					held_ext_q <= word;
					pend_q     <= 2'd1;
				end
				default: begin
					pend_q <= 2'd0;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// result assembly
	// ------------------------------------------------------------------
	logic                  emit;
	logic                  two_ext;
	logic [31:0]           ext_lo, ext_hi;
	logic [ADDR_WIDTH-1:0] inst_addr;
	logic [ADDR_WIDTH-1:0] target;
	res_t                  res, out_res;

	assign emit    = accept && (((cur_pend == 2'd0) && (dec.need == 2'd0)) ||
	                            (cur_pend == 2'd1));
	assign two_ext = (dec.need == 2'd2);
	assign ext_lo  = two_ext ? held_ext_q : word;
	assign ext_hi  = two_ext ? word : 32'd0;

	// branch target is relative to the address after the extension word
	assign target = cur_addr + WORD_BYTES + ext_lo[ADDR_WIDTH-1:0];

	always_comb begin
		if (cur_pend == 2'd0) begin
			inst_addr = cur_addr;
		end else if (two_ext) begin
			inst_addr = cur_addr - PAIR_BYTES;
		end else begin
			inst_addr = cur_addr - WORD_BYTES;
		end
	end

	always_comb begin
		res               = '0;
		res.inst_address  = 32'(inst_addr);
		res.inst_class    = dec.inst_class;
		res.op_code       = dec.op_code;
		res.dest_reg      = dec.dest_reg;
		res.src_reg_a     = dec.src_reg_a;
		res.src_reg_b     = dec.src_reg_b;
		res.small_imm     = dec.small_imm;
		res.bank_bits     = dec.bank_bits;
		res.decode_status = dec.status;
		if (cur_pend != 2'd0) begin
			res.ext_low  = ext_lo;
			res.ext_high = ext_hi;
			if (dec.branch_ok) begin
				res.branch_target = 32'(target);
			end
		end
	end

	vlid_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (res),
		.can_push  (can_push),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {out_res.decode_status, out_res.branch_target, out_res.ext_high,
	                  out_res.ext_low, out_res.bank_bits, out_res.small_imm,
	                  out_res.src_reg_b, out_res.src_reg_a, out_res.dest_reg,
	                  out_res.op_code, out_res.inst_class, out_res.inst_address};

endmodule

`default_nettype wire

/* rtl/vlid_checker.sv */
// ----------------------------------------------------------------------------
// vlid_checker
// port-level assertions of the decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vlid_checker import vlid_pkg::*; (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [175:0] m_tdata,
	input wire logic         psel,
	input wire logic         penable,
	input wire logic         pwrite,
	input wire logic [2:0]   paddr,
	input wire logic [31:0]  pwdata,
	input wire logic [31:0]  prdata,
	input wire logic         pready
);

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

	// a stalled result holds
	`ASSERT_NEXT(a_res_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata))

	// invalid class results carry only the address, the class marker and status
	`ASSERT_SAME(a_bad_class, clk, arst_n, m_tvalid && (m_tdata[175:174] == ST_BAD_CLASS),
		(m_tdata[35:32] == CLS_INVALID) && (m_tdata[173:36] == '0))

	// unsupported traps only come from the trap class
	`ASSERT_SAME(a_bad_trap, clk, arst_n, m_tvalid && (m_tdata[175:174] == ST_BAD_TRAP),
		m_tdata[35:32] == CLS_TRAP[3:0])

	// a start address write reads back
	`ASSERT_NEXT(a_cfg_read, clk, arst_n, cfg_wr,
		paddr[2] || (prdata == $past(pwdata)))

endmodule

bind variable_length_instruction_decoder_core vlid_checker u_vlid_checker (.*);

`default_nettype wire

/* bench/vlid_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vlid_tb_pkg
// opcode bounds and opcode groups of the decoder classes, shared by the
// stimulus side and the decode checker
// ----------------------------------------------------------------------------
package vlid_tb_pkg;

	// highest opcode of each class table
	localparam int unsigned ALU_OP_MAX     = 6;
	localparam int unsigned MUL_OP_MAX     = 8;
	localparam int unsigned CONV_OP_MAX    = 1;
	localparam int unsigned CMP_OP_MAX     = 1;
	localparam int unsigned SPECIAL_OP_MAX = 2;
	localparam int unsigned CTRL_OP_MAX    = 3;
	localparam int unsigned BR_OP_MAX      = 11;
	localparam int unsigned RM_OP_MAX      = 15;
	localparam int unsigned SHIFT_OP_MAX   = 7;
	localparam int unsigned LI_OP_MAX      = 7;
	localparam int unsigned CREG_OP_MAX    = 9;
	localparam int unsigned FLOAT_OP_MAX   = 6;

	// alu opcode with a single source: src a must be 0, no src a bank flag
	localparam int unsigned ALU_OP_SINGLE  = 6;
	// control opcode that names a register in src a
	localparam int unsigned CTRL_OP_REG    = 3;
	// branch opcodes up to this one take a register in src a
	localparam int unsigned BR_OP_REG_MAX  = 9;
	// load-immediate opcodes up to this one carry an immediate in bits 20..5
	localparam int unsigned LI_OP_IMM_MAX  = 1;

	// reg-mem opcodes with no base, index or scale (bit per opcode)
	localparam logic [15:0] RM_NO_BASE     = 16'h0228;
	// reg-mem opcodes with a float destination
	localparam logic [15:0] RM_FLOAT_DEST  = 16'h183C;
	// load-immediate opcodes with a float destination
	localparam logic [7:0]  LI_FLOAT_DEST  = 8'hD8;

endpackage

/* bench/vlid_decode_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vlid_decode_checker
// follows the word and result channels, decodes every accepted word on its
// own and compares each result with the oldest decode still due
// ----------------------------------------------------------------------------
module vlid_decode_checker import vlid_pkg::*, vlid_tb_pkg::*; #(
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	// [31:0] code_word, [32] restart, [39:33] zero
	input  logic [39:0]  s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] inst_address, [35:32] inst_class, [43:36] op_code,
	// [48:44] dest_reg, [53:49] src_reg_a, [58:54] src_reg_b,
	// [74:59] small_imm, [77:75] bank_bits, [109:78] ext_low,
	// [141:110] ext_high, [173:142] branch_target, [175:174] decode_status
	input  logic [175:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           mismatch_count,
	output int           expected_left
);

	localparam logic [31:0] ADDR_MASK = (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << ADDR_WIDTH) - 64'd1);

	// decoder state
	logic [31:0] start_addr;
	logic [31:0] next_addr;
	logic [1:0]  words_owed;
	logic [31:0] held_word;
	logic [31:0] held_ext;

	res_t        due_decodes[$];

	logic [31:0] word;
	logic [31:0] addr;
	logic [1:0]  need;
	res_t        made;
	res_t        want;
	res_t        seen;

	// field split of one instruction word; the address and extensions are left 0
	function automatic void decode_fields(input logic [31:0] w, output res_t r,
			output logic [1:0] owed);
		logic [5:0] cls;
		logic [4:0] rd;
		logic [4:0] ra;
		logic [4:0] rb;
		logic [4:0] op5;
		logic [5:0] op6;
		logic [7:0] trap;
		logic       bad;
		cls  = w[31:26];
		rd   = w[25:21];
		ra   = w[20:16];
		rb   = w[15:11];
		op5  = w[4:0];
		op6  = w[5:0];
		trap = w[15:8];
		r    = '0;
		owed = 2'd0;
		bad  = 1'b0;
		r.decode_status = ST_VALID;
		if (cls > CLS_FLOAT) begin
			r.inst_class    = CLS_INVALID;
			r.decode_status = ST_BAD_CLASS;
			return;
		end
		case (cls)
			CLS_ALU: begin
				r.op_code   = {3'd0, op5};
				r.dest_reg  = rd;
				r.src_reg_a = ra;
				r.src_reg_b = rb;
				r.bank_bits = w[10:8];
				bad = w[7:5] != 0 || op5 > ALU_OP_MAX ||
					(op5 == ALU_OP_SINGLE && (ra != 0 || w[9]));
			end
			CLS_MUL: begin
				r.op_code   = {2'd0, op6};
				r.dest_reg  = rd;
				r.src_reg_a = ra;
				r.src_reg_b = rb;
				bad = w[10:6] != 0 || op6 > MUL_OP_MAX;
			end
			CLS_CONV: begin
				r.op_code   = {2'd0, op6};
				r.dest_reg  = rd;
				r.src_reg_a = ra;
				bad = w[15:6] != 0 || op6 > CONV_OP_MAX;
			end
			CLS_CMP: begin
				r.op_code   = {3'd0, op5};
				r.dest_reg  = rd;
				r.src_reg_a = ra;
				bad = w[15:5] != 0 || op5 > CMP_OP_MAX;
			end
			CLS_SPECIAL: begin
				r.op_code  = {3'd0, op5};
				r.dest_reg = rd;
				bad = w[20:5] != 0 || op5 > SPECIAL_OP_MAX;
			end
			CLS_CTRL: begin
				r.op_code = {3'd0, op5};
				if (op5 == CTRL_OP_REG) begin
					r.src_reg_a = ra;
				end else begin
					bad = op5 > CTRL_OP_MAX || w[25:5] != 0;
				end
			end
			CLS_MOVE: begin
				r.dest_reg  = rd;
				r.src_reg_a = ra;
				bad = w[15:0] != 0;
			end
			CLS_BRANCH: begin
				r.op_code = {3'd0, op5};
				owed = 2'd1;
				if (op5 <= BR_OP_REG_MAX) begin
					r.src_reg_a = ra;
				end
				bad = op5 > BR_OP_MAX;
			end
			CLS_REGMEM: begin
				r.op_code = {3'd0, op5};
				if (op5 > RM_OP_MAX) begin
					bad = 1'b1;
				end else begin
					owed = (op5 == OP_RM_LDI) ? 2'd2 : 2'd1;
					r.dest_reg = rd;
					if (!RM_NO_BASE[op5[3:0]]) begin
						r.src_reg_a = ra;
						r.src_reg_b = rb;
						r.small_imm = {14'd0, w[7:6]};
					end
					if (RM_FLOAT_DEST[op5[3:0]]) begin
						r.bank_bits = BANK_DEST;
					end
				end
			end
			CLS_SHIFT: begin
				r.op_code   = {3'd0, op5};
				r.dest_reg  = rd;
				r.src_reg_a = ra;
				r.src_reg_b = rb;
				bad = w[10:5] != 0 || op5 > SHIFT_OP_MAX;
			end
			CLS_LOADIMM: begin
				r.op_code  = {3'd0, op5};
				r.dest_reg = rd;
				if (op5 <= LI_OP_IMM_MAX) begin
					r.small_imm = w[20:5];
				end
				if (op5 <= LI_OP_MAX && LI_FLOAT_DEST[op5[2:0]]) begin
					r.bank_bits = BANK_DEST;
				end
				bad = op5 > LI_OP_MAX;
			end
			CLS_CREG: begin
				r.op_code   = {3'd0, op5};
				r.dest_reg  = rd;
				r.src_reg_a = ra;
				bad = w[15:5] != 0 || op5 > CREG_OP_MAX;
			end
			CLS_TRAP: begin
				r.op_code = trap;
				if (trap == TRAP_NIL_GUARD || trap == TRAP_NIL_PTR) begin
					r.src_reg_a = ra;
				end else if (trap == TRAP_ARRAY) begin
					r.src_reg_a = ra;
					r.dest_reg  = rd;
				end else if (trap == TRAP_RANGE) begin
					r.src_reg_a = ra;
					r.small_imm = {8'd0, w[7:0]};
				end else begin
					r.decode_status = ST_BAD_TRAP;
				end
			end
			CLS_FLOAT: begin
				r.op_code   = {2'd0, op6};
				r.dest_reg  = rd;
				r.src_reg_a = ra;
				r.bank_bits = BANK_DA;
				bad = w[10:6] != 0 || rb != 0 || op6 > FLOAT_OP_MAX;
			end
			default: ;
		endcase
		r.inst_class = cls[3:0];
		if (bad) begin
			r.decode_status = ST_BAD_ENC;
		end
	endfunction

	task automatic compare_field(input string name, input logic [31:0] expected,
			input logic [31:0] actual);
		if (expected !== actual) begin
			$error("%s: expected %0h, actual %0h", name, expected, actual);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_addr     = '0;
			next_addr      = '0;
			words_owed     = '0;
			held_word      = '0;
			held_ext       = '0;
			mismatch_count = 0;
			due_decodes.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_START_ADDRESS) begin
				start_addr = pwdata;
			end

			// result side first: its decode was due before this edge's word
			if (m_tvalid && m_tready) begin
				seen.inst_address  = m_tdata[31:0];
				seen.inst_class    = m_tdata[35:32];
				seen.op_code       = m_tdata[43:36];
				seen.dest_reg      = m_tdata[48:44];
				seen.src_reg_a     = m_tdata[53:49];
				seen.src_reg_b     = m_tdata[58:54];
				seen.small_imm     = m_tdata[74:59];
				seen.bank_bits     = m_tdata[77:75];
				seen.ext_low       = m_tdata[109:78];
				seen.ext_high      = m_tdata[141:110];
				seen.branch_target = m_tdata[173:142];
				seen.decode_status = status_t'(m_tdata[175:174]);
				if (due_decodes.size() == 0) begin
					$error("result at %0h with no decode due", seen.inst_address);
					mismatch_count++;
				end else begin
					want = due_decodes.pop_front();
					compare_field("inst_address", want.inst_address, seen.inst_address);
					compare_field("inst_class", 32'(want.inst_class),
						32'(seen.inst_class));
					compare_field("op_code", 32'(want.op_code), 32'(seen.op_code));
					compare_field("dest_reg", 32'(want.dest_reg), 32'(seen.dest_reg));
					compare_field("src_reg_a", 32'(want.src_reg_a),
						32'(seen.src_reg_a));
					compare_field("src_reg_b", 32'(want.src_reg_b),
						32'(seen.src_reg_b));
					compare_field("small_imm", 32'(want.small_imm),
						32'(seen.small_imm));
					compare_field("bank_bits", 32'(want.bank_bits),
						32'(seen.bank_bits));
					compare_field("ext_low", want.ext_low, seen.ext_low);
					compare_field("ext_high", want.ext_high, seen.ext_high);
					compare_field("branch_target", want.branch_target, seen.branch_target);
					compare_field("decode_status", 32'(want.decode_status),
						32'(seen.decode_status));
				end
			end

			if (s_tvalid && s_tready) begin
				word = s_tdata[31:0];
				if (s_tdata[32]) begin
					next_addr  = start_addr & ADDR_MASK;
					words_owed = 2'd0;
				end
				addr      = next_addr & ADDR_MASK;
				next_addr = (addr + 32'd4) & ADDR_MASK;
				if (words_owed == 2'd0) begin
					decode_fields(word, made, need);
					if (need == 2'd0) begin
						made.inst_address = addr;
						due_decodes.push_back(made);
					end else begin
						held_word  = word;
						words_owed = need;
					end
				end else if (words_owed == 2'd2) begin
					held_ext   = word;
					words_owed = 2'd1;
				end else begin
					words_owed = 2'd0;
					decode_fields(held_word, made, need);
					if (need == 2'd2) begin
						made.ext_low      = held_ext;
						made.ext_high     = word;
						made.inst_address = (addr - 32'd8) & ADDR_MASK;
					end else begin
						made.ext_low      = word;
						made.inst_address = (addr - 32'd4) & ADDR_MASK;
					end
					if (held_word[31:26] == CLS_BRANCH && held_word[4:0] <= BR_OP_MAX) begin
						made.branch_target = (addr + 32'd4 + made.ext_low) & ADDR_MASK;
					end
					due_decodes.push_back(made);
				end
			end
		end
		expected_left = due_decodes.size();
	end

endmodule

/* bench/tb_variable_length_instruction_decoder_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_variable_length_instruction_decoder_core
// drives code word streams with random gaps and restarts into the decoder,
// rewrites the start address between phases and leaves the checking to the
// decode checker beside the block and the assertions bound to the core
// ----------------------------------------------------------------------------
module tb_variable_length_instruction_decoder_core;
	import vlid_pkg::*;
	import vlid_tb_pkg::*;

	localparam int ADDR_WIDTH  = ADDR_WIDTH_DEF;
	localparam int PHASES      = 6;
	localparam int PHASE_WORDS = 210;
	// far above the worst-case run time
	localparam int CYCLE_LIMIT = 200000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// [31:0] code_word, [32] restart, [39:33] zero
	logic [39:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// [31:0] inst_address, [35:32] inst_class, [43:36] op_code,
	// [48:44] dest_reg, [53:49] src_reg_a, [58:54] src_reg_b,
	// [74:59] small_imm, [77:75] bank_bits, [109:78] ext_low,
	// [141:110] ext_high, [173:142] branch_target, [175:174] decode_status
	logic [175:0] m_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	int           mismatch_count;
	int           expected_left;
	int           cycle_count = 0;
	int           words_sent = 0;

	// both sides run without gaps while these are set
	logic         tx_quiet = 1'b0;
	logic         rx_quiet = 1'b0;
	logic         rx_took = 1'b0;
	int           rx_hold = 0;

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	variable_length_instruction_decoder_core #(
		.ADDR_WIDTH(ADDR_WIDTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	vlid_decode_checker #(
		.ADDR_WIDTH(ADDR_WIDTH)
	) decode_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.mismatch_count(mismatch_count),
		.expected_left (expected_left)
	);

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("variable_length_instruction_decoder_core test failed");
			$finish;
		end
	end

	// result side: after each taken result, tready may be held low unless rx_quiet is set
	always @(posedge clk) begin
		rx_took <= m_tvalid && m_tready;
	end

	always @(negedge clk) begin
		if (rx_took) begin
			rx_hold = rx_quiet ? 0 : $urandom_range(4);
		end
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// one word request, after a random idle gap unless tx_quiet is set
	task automatic send_word(input logic [31:0] word, input logic restart);
		int gap;
		// switch idling on and off in stretches
		if (words_sent % 40 == 0) begin
			tx_quiet = ($urandom_range(3) == 0);
			rx_quiet = tx_quiet;
		end
		gap = tx_quiet ? 0 : $urandom_range(4);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= {7'd0, 1'($urandom), 32'($urandom)};
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, restart, word};
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	// stop sending until every due result has come, then let the pipe empty
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_left != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// apb setup and access cycle
	task automatic write_start_address(input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_START_ADDRESS;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// mostly well-formed: reserved bits cleared and opcode inside the table
	function automatic logic [31:0] random_instruction();
		logic [5:0]  cls;
		logic [25:0] body;
		cls  = 6'($urandom_range(CLS_FLOAT, CLS_ALU));
		body = 26'($urandom);
		if ($urandom_range(3) != 0) begin
			case (cls)
				CLS_ALU: begin
					body[7:5] = '0;
					body[4:0] = 5'($urandom_range(ALU_OP_MAX));
				end
				CLS_MUL: begin
					body[10:6] = '0;
					body[5:0]  = 6'($urandom_range(MUL_OP_MAX));
				end
				CLS_CONV: begin
					body[15:6] = '0;
					body[5:0]  = 6'($urandom_range(CONV_OP_MAX));
				end
				CLS_CMP: begin
					body[15:5] = '0;
					body[4:0]  = 5'($urandom_range(CMP_OP_MAX));
				end
				CLS_SPECIAL: begin
					body[20:5] = '0;
					body[4:0]  = 5'($urandom_range(SPECIAL_OP_MAX));
				end
				CLS_CTRL: begin
					body[4:0] = 5'($urandom_range(CTRL_OP_MAX));
					if (body[4:0] != CTRL_OP_REG) begin
						body[25:5] = '0;
					end
				end
				CLS_MOVE: body[15:0] = '0;
				CLS_BRANCH: body[4:0] = 5'($urandom_range(BR_OP_MAX));
				CLS_REGMEM: body[4:0] = 5'($urandom_range(RM_OP_MAX));
				CLS_SHIFT: begin
					body[10:5] = '0;
					body[4:0]  = 5'($urandom_range(SHIFT_OP_MAX));
				end
				CLS_LOADIMM: body[4:0] = 5'($urandom_range(LI_OP_MAX));
				CLS_CREG: begin
					body[15:5] = '0;
					body[4:0]  = 5'($urandom_range(CREG_OP_MAX));
				end
				CLS_TRAP: begin
					case ($urandom_range(3))
						0: body[15:8] = TRAP_RANGE;
						1: body[15:8] = TRAP_ARRAY;
						2: body[15:8] = TRAP_NIL_GUARD;
						default: body[15:8] = TRAP_NIL_PTR;
					endcase
				end
				CLS_FLOAT: begin
					body[15:6] = '0;
					body[5:0]  = 6'($urandom_range(FLOAT_OP_MAX));
				end
				default: ;
			endcase
		end
		return {cls, body};
	endfunction

	// displacements and immediates, edges included
	function automatic logic [31:0] random_extension();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return -32'($urandom_range(64));
			default: return 32'($urandom);
		endcase
	endfunction

	// instruction word and its extension words; some noise and broken runs
	task automatic send_instruction(input logic force_restart);
		logic [31:0] w;
		int          pick;
		int          ext_words;
		pick = $urandom_range(99);
		if (pick < 5) begin
			w = $urandom;
		end else if (pick < 10) begin
			w = {6'($urandom_range(63, CLS_INVALID)), 26'($urandom)};
		end else begin
			w = random_instruction();
		end
		send_word(w, force_restart || $urandom_range(59) == 0);
		ext_words = 0;
		if (w[31:26] == CLS_BRANCH) begin
			ext_words = 1;
		end else if (w[31:26] == CLS_REGMEM && w[4:0] <= RM_OP_MAX) begin
			ext_words = (w[4:0] == OP_RM_LDI) ? 2 : 1;
		end
		// a restart on an extension word drops the instruction in flight
		repeat (ext_words) send_word(random_extension(), $urandom_range(39) == 0);
		if ($urandom_range(149) == 0) begin
			settle();
		end
	endtask

	initial begin
		logic [31:0] phase_start[PHASES];
		int          target;
		phase_start = '{32'hFFFF_FFF4, 32'hFFFF_FFFF, 32'h0000_0000,
			32'($urandom), 32'h0000_0002, 32'h7FFF_FFFC};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		write_start_address(32'h0000_1000);

		// directed words; the first one decodes at the reset address
		send_word({CLS_ALU, 26'd0}, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);                       // invalid class
		send_word({CLS_ALU, 5'd31, 5'd1, 5'd31, 3'b111, 3'b000, 5'(ALU_OP_SINGLE)}, 1'b1);
		send_word({CLS_ALU, 15'h7FFF, 3'b101, 3'b111, 5'd2}, 1'b0);
		send_word({CLS_MUL, 15'h7FFF, 5'd0, 6'(MUL_OP_MAX)}, 1'b0);
		send_word({CLS_MUL, 20'd0, 6'(MUL_OP_MAX + 1)}, 1'b0);   // beyond the table
		send_word({CLS_CONV, 10'h3FF, 10'd0, 6'(CONV_OP_MAX)}, 1'b0);
		send_word({CLS_CMP, 10'h3FF, 11'd0, 5'(CMP_OP_MAX)}, 1'b0);
		send_word({CLS_SPECIAL, 5'd31, 16'd0, 5'(SPECIAL_OP_MAX)}, 1'b0);
		send_word({CLS_CTRL, 21'h1F_FFFF, 5'(CTRL_OP_REG)}, 1'b0);
		send_word({CLS_CTRL, 21'd0, 5'(CTRL_OP_MAX + 1)}, 1'b0);
		send_word({CLS_MOVE, 10'h3FF, 16'h0001}, 1'b0);        // reserved bit set
		// branch back across the address
		send_word({CLS_BRANCH, 5'd0, 5'd31, 11'd0, 5'd0}, 1'b0);
		send_word(32'hFFFF_FFF0, 1'b0);
		// invalid branch still takes its extension
		send_word({CLS_BRANCH, 21'h1F_FFFF, 5'(BR_OP_MAX + 1)}, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b0);
		// 64-bit immediate load
		send_word({CLS_REGMEM, 21'h1F_FFFF, OP_RM_LDI}, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word({CLS_REGMEM, 21'h1F_FFFF, 5'h1F}, 1'b0);    // invalid, no extension
		send_word({CLS_SHIFT, 15'h7FFF, 6'd0, 5'(SHIFT_OP_MAX)}, 1'b0);
		send_word({CLS_LOADIMM, 5'd31, 16'hFFFF, 5'd0}, 1'b0);
		send_word({CLS_CREG, 10'h3FF, 11'd0, 5'(CREG_OP_MAX)}, 1'b0);
		send_word({CLS_TRAP, 10'h3FF, TRAP_RANGE, 8'hFF}, 1'b0);
		send_word({CLS_TRAP, 10'h3FF, TRAP_NIL_GUARD, 8'h00}, 1'b0);
		send_word({CLS_TRAP, 10'h3FF, 8'hFF, 8'h00}, 1'b0);   // unsupported trap
		send_word({CLS_FLOAT, 10'h3FF, 10'd0, 6'(FLOAT_OP_MAX)}, 1'b0);
		// restart while a branch waits for its extension
		send_word({CLS_BRANCH, 21'd0, 5'd1}, 1'b0);
		send_word({CLS_SHIFT, 21'd0, 5'd0}, 1'b1);

		// random phases, each with its own start address
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_start_address(phase_start[ph]);
			target = words_sent + PHASE_WORDS;
			send_instruction(1'b1);
			while (words_sent < target) begin
				send_instruction(1'b0);
			end
		end

		settle();
		repeat (4) @(negedge clk);
		if (mismatch_count == 0 && expected_left == 0) begin
			$display("variable_length_instruction_decoder_core test passed");
		end else begin
			$display("variable_length_instruction_decoder_core test failed");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/vlid_pkg.sv
rtl/vlid_decode.sv
rtl/vlid_out_buf.sv
rtl/variable_length_instruction_decoder_core.sv
rtl/vlid_checker.sv
bench/vlid_tb_pkg.sv
bench/vlid_decode_checker.sv
bench/tb_variable_length_instruction_decoder_core.sv
